// ===== src/sale_pkg.sv =====
package sale_pkg;

    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 3;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_REWIND = 3'd4,
        OP_READ   = 3'd5
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_PAST_END  = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

// ===== src/sale_ctrl.sv =====
module sale_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sale_pkg::t_dp_status  i_status,
    output sale_pkg::t_ctl_cmd    o_cmd
);

    sale_pkg::t_state r_state;
    sale_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sale_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sale_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = sale_pkg::S_EXEC;
                end
            end
            sale_pkg::S_EXEC: begin
                // The result register must be free before the table is touched.
                if (!i_status.out_busy) begin
                    n_state = sale_pkg::S_IDLE;
                end
            end
            default: n_state = sale_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        unique case (r_state)
            sale_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            sale_pkg::S_EXEC: begin
                o_cmd.exec = !i_status.out_busy;
            end
            default: ;
        endcase
    end

endmodule

// ===== src/sale_dp.sv =====
module sale_dp #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [sale_pkg::OP_BITS-1:0]    i_op,
    input  logic [KEY_BITS-1:0]             i_key,
    input  sale_pkg::t_ctl_cmd              i_cmd,
    output sale_pkg::t_dp_status            o_status,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [KEY_BITS-1:0]             o_value,
    output logic                            o_found,
    output logic [sale_pkg::STATUS_BITS-1:0] o_status_code,
    output logic [$clog2(CAPACITY+1)-1:0]   o_count,
    output logic                            o_is_full,
    output logic                            o_is_empty
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    // Operation registers, loaded when the item is taken.
    sale_pkg::t_op     r_op;
    logic [KEY_BITS-1:0] r_key;

    // Row of shift cells holding the sorted keys.
    logic [KEY_BITS-1:0] r_cells [CAPACITY];
    logic [KEY_BITS-1:0] n_cells [CAPACITY];

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_cursor;
    logic [CW-1:0] n_cursor;

    logic [CAPACITY-1:0] w_live;
    logic [CAPACITY-1:0] w_gt;
    logic [CAPACITY-1:0] w_ge;
    logic [CAPACITY-1:0] w_eq;
    logic                w_any_eq;
    logic [KEY_BITS-1:0] w_rd_data;

    logic                do_ins;
    logic                do_del;
    logic [KEY_BITS-1:0] n_value;
    logic                n_found;
    sale_pkg::t_status   n_code;

    logic                r_out_valid;
    logic [KEY_BITS-1:0] r_out_value;
    logic                r_out_found;
    sale_pkg::t_status   r_out_code;
    logic [CW-1:0]       r_out_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= sale_pkg::t_op'(i_op);
            r_key <= i_key;
        end
    end

    // Every cell compares its own key against the operation key in parallel.
    // Since the row is sorted, these flags mark the insert and delete points.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic w_prev_gt;
        logic [KEY_BITS-1:0] w_prev;
        logic [KEY_BITS-1:0] w_next;

        assign w_live[g] = CW'(g) < r_count;
        assign w_gt[g]   = w_live[g] && (r_cells[g] >  r_key);
        assign w_ge[g]   = w_live[g] && (r_cells[g] >= r_key);
        assign w_eq[g]   = w_live[g] && (r_cells[g] == r_key);

        if (g == 0) begin : g_first
            assign w_prev_gt = 1'b0;
            assign w_prev    = r_cells[g];
        end else begin : g_mid
            assign w_prev_gt = w_gt[g-1];
            assign w_prev    = r_cells[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next = r_cells[g];
        end else begin : g_body
            assign w_next = r_cells[g+1];
        end

        assign n_cells[g] =
            (do_ins && w_prev_gt)                                  ? w_prev :
            (do_ins && (w_gt[g] || (CW'(g) == r_count)))           ? r_key  :
            (do_del && w_ge[g])                                    ? w_next :
                                                                     r_cells[g];

        always_ff @(posedge i_clk) begin
            if (i_cmd.exec && (do_ins || do_del)) begin
                r_cells[g] <= n_cells[g];
            end
        end
    end

    assign w_any_eq  = |w_eq;
    assign w_rd_data = r_cells[r_cursor[IW-1:0]];

    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        n_value  = '0;
        n_found  = 1'b0;
        n_code   = sale_pkg::ST_OK;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        case (r_op)
            sale_pkg::OP_INSERT: begin
                if (r_count == CW'(CAPACITY)) begin
                    n_code = sale_pkg::ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            sale_pkg::OP_DELETE: begin
                if (r_count == '0) begin
                    n_code = sale_pkg::ST_EMPTY;
                end else if (w_any_eq) begin
                    do_del  = 1'b1;
                    n_found = 1'b1;
                    n_count = r_count - CW'(1);
                end else begin
                    n_code = sale_pkg::ST_NOT_FOUND;
                end
            end
            sale_pkg::OP_LOOKUP: begin
                // A hit returns the stored key, which equals the search key.
                if (w_any_eq) begin
                    n_value = r_key;
                    n_found = 1'b1;
                end else begin
                    n_code = sale_pkg::ST_NOT_FOUND;
                end
            end
            sale_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            sale_pkg::OP_REWIND: begin
                n_cursor = '0;
            end
            sale_pkg::OP_READ: begin
                if (r_cursor < r_count) begin
                    n_value  = w_rd_data;
                    n_cursor = r_cursor + CW'(1);
                end else begin
                    n_code = sale_pkg::ST_PAST_END;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
        end else if (i_cmd.exec) begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_value <= n_value;
            r_out_found <= n_found;
            r_out_code  <= n_code;
            r_out_count <= n_count;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_ready;
    assign o_valid           = r_out_valid;
    assign o_value           = r_out_value;
    assign o_found           = r_out_found;
    assign o_status_code     = r_out_code;
    assign o_count           = r_out_count;
    assign o_is_full         = r_out_count == CW'(CAPACITY);
    assign o_is_empty        = r_out_count == '0;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= CW'(CAPACITY))
        else $error("read cursor above capacity");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> !(r_out_valid && !i_ready))
        else $error("result register overwritten while stalled");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == sale_pkg::OP_INSERT && r_count != CW'(CAPACITY))
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the table");

    a_delete_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && do_del) |-> (w_any_eq && r_count != '0))
        else $error("delete shifted without a match");
`endif

endmodule

// ===== src/sorted_array_list_engine.sv =====
// Sorted key table with insert, delete, lookup, clear and ordered read-out.
// Input channel: i_valid / o_ready carry i_op and i_key. An item is taken
// when both are high. Output channel: o_valid / i_ready carry o_value,
// o_found, o_status, o_count, o_is_full and o_is_empty; exactly one result
// leaves for every item taken, in order.
// Timing: an item is taken in the idle state and executed in the execute state
// that follows, once the output register is free; no new item is taken until
// the previous one has executed. The execute cycle is set by the row of shift cells: every
// cell compares its key with the item key and shifts in one step.
// Stalls: the result waits in an output register. While it waits, the next
// item is still taken, but it is not executed until the receiver takes the
// previous result, and meanwhile the input side holds o_ready low.
// Reset (i_rst_n low at a clock edge) empties the table, rewinds the read
// cursor and drops any pending result; the key cells are not cleared.
module sorted_array_list_engine #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [sale_pkg::OP_BITS-1:0]     i_op,
    input  logic [KEY_BITS-1:0]              i_key,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [KEY_BITS-1:0]              o_value,
    output logic                             o_found,
    output logic [sale_pkg::STATUS_BITS-1:0] o_status,
    output logic [$clog2(CAPACITY+1)-1:0]    o_count,
    output logic                             o_is_full,
    output logic                             o_is_empty
);

    sale_pkg::t_ctl_cmd   w_cmd;
    sale_pkg::t_dp_status w_status;

    sale_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    sale_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_value       (o_value),
        .o_found       (o_found),
        .o_status_code (o_status),
        .o_count       (o_count),
        .o_is_full     (o_is_full),
        .o_is_empty    (o_is_empty)
    );

endmodule

// ===== tb/sorted_array_list_engine_tb.sv =====
module sorted_array_list_engine_tb;
    import sale_pkg::*;

    localparam int CAPACITY        = 64;
    localparam int KEY_BITS        = 32;
    localparam int COUNT_BITS      = $clog2(CAPACITY + 1);
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STUCK_LIMIT     = 4000;
    localparam int REPORT_LIMIT    = 10;

    // Op codes the block does not define; they must act as a no-op.
    localparam logic [OP_BITS-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_BITS-1:0] OP_UNUSED_B = 3'd7;

    typedef struct packed {
        logic [KEY_BITS-1:0]   value;
        logic                  found;
        t_status               status;
        logic [COUNT_BITS-1:0] count;
        logic                  is_full;
        logic                  is_empty;
    } t_reply;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [OP_BITS-1:0]     i_op = '0;
    logic [KEY_BITS-1:0]    i_key = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [KEY_BITS-1:0]    o_value;
    logic                   o_found;
    logic [STATUS_BITS-1:0] o_status;
    logic [COUNT_BITS-1:0]  o_count;
    logic                   o_is_full;
    logic                   o_is_empty;

    // Shadow copy of the table, updated as each item is accepted.
    logic [KEY_BITS-1:0] table_keys [CAPACITY];
    int                  table_count = 0;
    int                  table_cursor = 0;

    t_reply      replies_due[$];
    int          mismatches = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    int          stuck_cycles = 0;

    sorted_array_list_engine #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_op       (i_op),
        .i_key      (i_key),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_value    (o_value),
        .o_found    (o_found),
        .o_status   (o_status),
        .o_count    (o_count),
        .o_is_full  (o_is_full),
        .o_is_empty (o_is_empty)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_reply apply_table_op(logic [OP_BITS-1:0] op, logic [KEY_BITS-1:0] key);
        t_reply r;
        int     pos;
        int     j;
        int     lo;
        int     hi;
        int     mid;
        r.value  = '0;
        r.found  = 1'b0;
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (table_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < table_count && table_keys[pos] <= key) pos++;
                    for (j = table_count; j > pos; j--) table_keys[j] = table_keys[j-1];
                    table_keys[pos] = key;
                    table_count++;
                end
            end
            OP_DELETE: begin
                if (table_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < table_count && table_keys[pos] != key) pos++;
                    if (pos < table_count) begin
                        for (j = pos + 1; j < table_count; j++) table_keys[j-1] = table_keys[j];
                        table_count--;
                        r.found = 1'b1;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
            end
            OP_LOOKUP: begin
                lo = 0;
                hi = table_count - 1;
                while (lo <= hi && !r.found) begin
                    mid = lo + (hi - lo) / 2;
                    if (key < table_keys[mid]) begin
                        hi = mid - 1;
                    end else if (key > table_keys[mid]) begin
                        lo = mid + 1;
                    end else begin
                        r.value = table_keys[mid];
                        r.found = 1'b1;
                    end
                end
                if (!r.found) r.status = ST_NOT_FOUND;
            end
            OP_CLEAR: begin
                table_count = 0;
            end
            OP_REWIND: begin
                table_cursor = 0;
            end
            OP_READ: begin
                if (table_cursor < table_count) begin
                    r.value = table_keys[table_cursor];
                    table_cursor++;
                end else begin
                    r.status = ST_PAST_END;
                end
            end
            default: begin
            end
        endcase
        r.count    = COUNT_BITS'(table_count);
        r.is_full  = (table_count == CAPACITY);
        r.is_empty = (table_count == 0);
        return r;
    endfunction

    // Half the time a key already in the table, so that lookups and deletes hit,
    // with small keys for duplicates and full-range keys for every bit.
    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(7))
            0, 1, 2, 3: return (table_count > 0) ?
                table_keys[$urandom_range(table_count - 1)] : $urandom;
            4, 5: return $urandom_range(15);
            6: return $urandom_range(1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_BITS-1:0] pick_op(int grow);
        int r;
        r = $urandom_range(grow + 59);
        if (r < grow) return OP_INSERT;
        r -= grow;
        if (r < 20) return OP_DELETE;
        if (r < 40) return OP_LOOKUP;
        if (r < 53) return OP_READ;
        if (r < 57) return OP_REWIND;
        if (r < 58) return OP_CLEAR;
        return r[0] ? OP_UNUSED_A : OP_UNUSED_B;
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic issue_op(logic [OP_BITS-1:0] op, logic [KEY_BITS-1:0] key);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        do @(posedge i_clk); while (!o_ready);
        replies_due.push_back(apply_table_op(op, key));
    endtask

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            if (replies_due.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected result: value=%h status=%0d count=%0d",
                             o_value, o_status, o_count);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                if (o_value !== want.value || o_found !== want.found ||
                    o_status !== want.status || o_count !== want.count ||
                    o_is_full !== want.is_full || o_is_empty !== want.is_empty) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display({"mismatch exp: value=%h found=%b status=%0d",
                                  " count=%0d full=%b empty=%b"},
                                 want.value, want.found, want.status, want.count,
                                 want.is_full, want.is_empty);
                        $display({"         got: value=%h found=%b status=%0d",
                                  " count=%0d full=%b empty=%b"},
                                 o_value, o_found, o_status, o_count, o_is_full, o_is_empty);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        issue_op(OP_READ, '0);
        issue_op(OP_DELETE, 32'd5);
        issue_op(OP_LOOKUP, 32'd5);
        issue_op(OP_INSERT, 32'hFFFF_FFFF);
        issue_op(OP_INSERT, 32'h0000_0000);
        issue_op(OP_INSERT, 32'h0000_0000);
        issue_op(OP_INSERT, 32'h8000_0000);
        issue_op(OP_INSERT, 32'h7FFF_FFFF);
        issue_op(OP_LOOKUP, 32'h0000_0000);
        issue_op(OP_LOOKUP, 32'hFFFF_FFFF);
        issue_op(OP_LOOKUP, 32'h0000_1234);
        issue_op(OP_DELETE, 32'h0000_1234);
        issue_op(OP_DELETE, 32'h0000_0000);
        issue_op(OP_REWIND, '1);
        repeat (5) issue_op(OP_READ, '1);
        issue_op(OP_UNUSED_A, 32'h5A5A_A5A5);
        issue_op(OP_UNUSED_B, 32'hA5A5_5A5A);
        // The cursor survives a clear, so later reads start past the end.
        issue_op(OP_CLEAR, '0);
        issue_op(OP_READ, '0);
        issue_op(OP_INSERT, 32'd9);
        issue_op(OP_READ, '0);
    endtask

    task automatic test_full_table();
        idle_pct  = 20;
        stall_pct = 20;
        issue_op(OP_CLEAR, '0);
        issue_op(OP_REWIND, '0);
        repeat (CAPACITY) issue_op(OP_INSERT, pick_key());
        issue_op(OP_INSERT, '0);
        issue_op(OP_INSERT, '1);
        issue_op(OP_INSERT, pick_key());
        issue_op(OP_LOOKUP, pick_key());
        issue_op(OP_READ, '0);
        issue_op(OP_DELETE, pick_key());
        issue_op(OP_INSERT, pick_key());
        issue_op(OP_REWIND, '0);
        repeat (CAPACITY + 1) issue_op(OP_READ, $urandom);
        while (table_count > 0)
            issue_op(OP_DELETE, table_keys[$urandom_range(table_count - 1)]);
        issue_op(OP_DELETE, $urandom);
        issue_op(OP_LOOKUP, $urandom);
    endtask

    task automatic test_random(int n_items, int sender_idle, int receiver_stall, int grow);
        logic [OP_BITS-1:0] op;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        repeat (n_items) begin
            op = pick_op(grow);
            issue_op(op, (op == OP_INSERT || op == OP_DELETE || op == OP_LOOKUP) ?
                     pick_key() : $urandom);
        end
    endtask

    // The receiver holds off while items keep coming, so the block backs up.
    task automatic test_backpressure();
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = HOLD_OFF_CYCLES;
        repeat (40) issue_op(pick_op(50), pick_key());
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        test_random(290, 0, 0, 45);
        test_random(290, 53, 0, 60);
        test_random(290, 0, 53, 50);
        test_random(260, 29, 29, 75);
        test_backpressure();
        i_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
